[sv/btr_pkg.sv]
// ----------------------------------------------------------------------------
// btr_pkg: shared types and register codes for the beam-triggered reward
// and pulse-train core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package btr_pkg;

  localparam int CFG_WIDTH       = 32;
  localparam int CFG_INDEX_WIDTH = 3;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_REWARD_TIME   = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_REWARD_ENABLE = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SINGLE_SHOT   = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LASER_ENABLE  = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_STIM_DELAY    = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_STIM_LENGTH   = 3'd5;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PULSE_WIDTH   = 3'd6;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PULSE_PERIOD  = 3'd7;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] reward_time;
    logic                 reward_enable;
    logic                 single_shot;
    logic                 laser_enable;
    logic [CFG_WIDTH-1:0] stim_delay;
    logic [CFG_WIDTH-1:0] stim_length;
    logic [CFG_WIDTH-1:0] pulse_width;
    logic [CFG_WIDTH-1:0] pulse_period;
  } cfg_t;

  typedef struct packed {
    logic nose_present;
    logic entry_event;
    logic exit_event;
    logic reward_started;
    logic solenoid_on;
    logic stim_trigger;
  } rew_status_t;

  typedef struct packed {
    logic stim_started;
    logic stim_ended;
    logic laser_level;
  } stim_status_t;

endpackage

[sv/btr_reward.sv]
// ----------------------------------------------------------------------------
// btr_reward: beam edge tracking, single-shot spent mark and solenoid
// pulse timer. State advances on each accepted request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module btr_reward #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic                 beam_level,
  input  logic                 reward_now,
  input  logic                 rearm,
  input  btr_pkg::cfg_t        cfg,
  output btr_pkg::rew_status_t status
);

  localparam int CW = ((TIME_WIDTH > btr_pkg::CFG_WIDTH) ? TIME_WIDTH : btr_pkg::CFG_WIDTH) + 1;

  logic                  beam_state;
  logic                  reward_busy;
  logic                  reward_spent;
  logic [TIME_WIDTH-1:0] reward_count;

  logic                  beam_state_next;
  logic                  reward_busy_next;
  logic                  reward_spent_next;
  logic [TIME_WIDTH-1:0] reward_count_next;

  logic                  spent_cleared;
  logic                  entry;
  logic                  leave;
  logic                  want;
  logic                  start;
  logic                  busy_mid;
  logic [TIME_WIDTH-1:0] count_inc;

  always_comb begin
    spent_cleared     = rearm ? 1'b0 : reward_spent;
    entry             = (beam_level != beam_state) && beam_level;
    leave             = (beam_level != beam_state) && !beam_level;
    beam_state_next   = beam_level;
    want              = (entry && cfg.reward_enable && !spent_cleared) || reward_now;
    reward_spent_next = (entry && cfg.single_shot) ? 1'b1 : spent_cleared;
    count_inc         = reward_count;
    if (reward_busy && (reward_count != {TIME_WIDTH{1'b1}})) begin
      count_inc = reward_count + TIME_WIDTH'(1);
    end
    start             = want && (cfg.reward_time != '0);
    busy_mid          = start || reward_busy;
    reward_count_next = start ? '0 : count_inc;
    reward_busy_next  = busy_mid && !(CW'(reward_count_next) > CW'(cfg.reward_time));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beam_state   <= 1'b0;
      reward_busy  <= 1'b0;
      reward_spent <= 1'b0;
      reward_count <= '0;
    end else if (go) begin
      beam_state   <= beam_state_next;
      reward_busy  <= reward_busy_next;
      reward_spent <= reward_spent_next;
      reward_count <= reward_count_next;
    end
  end

  always_comb begin
    status.nose_present   = beam_state_next;
    status.entry_event    = entry;
    status.exit_event     = leave;
    status.reward_started = start;
    status.solenoid_on    = reward_busy_next;
    status.stim_trigger   = entry && cfg.laser_enable;
  end

endmodule

[sv/btr_stim.sv]
// ----------------------------------------------------------------------------
// btr_stim: laser stimulus timer. Delay, then a pulse train of set width
// and period inside the stimulus window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module btr_stim #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  go,
  input  logic                  trigger,
  input  btr_pkg::cfg_t         cfg,
  output btr_pkg::stim_status_t status
);

  localparam int CW = ((TIME_WIDTH > btr_pkg::CFG_WIDTH) ? TIME_WIDTH : btr_pkg::CFG_WIDTH) + 1;

  logic                  stim_busy;
  logic                  laser_state;
  logic [TIME_WIDTH-1:0] stim_count;
  logic [TIME_WIDTH-1:0] next_pulse_at;

  logic                  stim_busy_next;
  logic                  laser_state_next;
  logic [TIME_WIDTH-1:0] stim_count_next;
  logic [TIME_WIDTH-1:0] next_pulse_at_next;

  logic                  ended;
  logic [TIME_WIDTH-1:0] offset;
  logic [CW-1:0]         off_end;
  logic [CW-1:0]         period_sum;

  always_comb begin
    stim_busy_next     = stim_busy;
    laser_state_next   = laser_state;
    stim_count_next    = stim_count;
    next_pulse_at_next = next_pulse_at;
    ended              = 1'b0;
    if (stim_busy && (stim_count != {TIME_WIDTH{1'b1}})) begin
      stim_count_next = stim_count + TIME_WIDTH'(1);
    end
    if (trigger) begin
      stim_busy_next     = 1'b1;
      stim_count_next    = '0;
      next_pulse_at_next = '0;
    end
    offset     = stim_count_next - TIME_WIDTH'(cfg.stim_delay);
    off_end    = CW'(next_pulse_at_next) + CW'(cfg.pulse_width);
    period_sum = CW'(next_pulse_at_next) + CW'(cfg.pulse_period);
    if (stim_busy_next && (CW'(stim_count_next) > CW'(cfg.stim_delay))) begin
      if (CW'(offset) >= CW'(cfg.stim_length)) begin
        stim_busy_next   = 1'b0;
        laser_state_next = 1'b0;
        ended            = 1'b1;
      end else if ((offset >= next_pulse_at_next) && !laser_state_next) begin
        laser_state_next = 1'b1;
      end else if (laser_state_next && (CW'(offset) >= off_end)) begin
        laser_state_next = 1'b0;
        if (period_sum >= CW'({TIME_WIDTH{1'b1}})) begin
          next_pulse_at_next = {TIME_WIDTH{1'b1}};
        end else begin
          next_pulse_at_next = period_sum[TIME_WIDTH-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stim_busy     <= 1'b0;
      laser_state   <= 1'b0;
      stim_count    <= '0;
      next_pulse_at <= '0;
    end else if (go) begin
      stim_busy     <= stim_busy_next;
      laser_state   <= laser_state_next;
      stim_count    <= stim_count_next;
      next_pulse_at <= next_pulse_at_next;
    end
  end

  always_comb begin
    status.stim_started = trigger;
    status.stim_ended   = ended;
    status.laser_level  = laser_state_next;
  end

endmodule

[sv/beam_triggered_reward_and_pulse_train_core.sv]
// ----------------------------------------------------------------------------
// beam_triggered_reward_and_pulse_train_core: beam-triggered solenoid reward
// and laser pulse-train generator, one request per timebase tick.
// An accepted request is held in the input register and its result is then captured
// in the result register. Throughput: one request per cycle unless out_stall holds
// the output, set by the one pass of counter add and compare between the registers.
// Reset (rst, synchronous) clears configuration, timers and both stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module beam_triggered_reward_and_pulse_train_core #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [btr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [btr_pkg::CFG_WIDTH-1:0]       cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                beam_level,
  input  logic                                reward_now,
  input  logic                                rearm,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                solenoid_on,
  output logic                                laser_level,
  output logic                                nose_present,
  output logic                                entry_event,
  output logic                                exit_event,
  output logic                                reward_started,
  output logic                                stim_started,
  output logic                                stim_ended
);

  btr_pkg::cfg_t         cfg;
  btr_pkg::rew_status_t  rew_status;
  btr_pkg::stim_status_t stim_status;

  logic in_q_valid;
  logic beam_q;
  logic reward_now_q;
  logic rearm_q;
  logic out_ready;
  logic go;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        btr_pkg::REG_REWARD_TIME:   cfg.reward_time   <= cfg_data;
        btr_pkg::REG_REWARD_ENABLE: cfg.reward_enable <= cfg_data[0];
        btr_pkg::REG_SINGLE_SHOT:   cfg.single_shot   <= cfg_data[0];
        btr_pkg::REG_LASER_ENABLE:  cfg.laser_enable  <= cfg_data[0];
        btr_pkg::REG_STIM_DELAY:    cfg.stim_delay    <= cfg_data;
        btr_pkg::REG_STIM_LENGTH:   cfg.stim_length   <= cfg_data;
        btr_pkg::REG_PULSE_WIDTH:   cfg.pulse_width   <= cfg_data;
        btr_pkg::REG_PULSE_PERIOD:  cfg.pulse_period  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_ready = !out_valid || !out_stall;
  assign go        = in_q_valid && out_ready;
  assign in_stall  = in_q_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      beam_q       <= beam_level;
      reward_now_q <= reward_now;
      rearm_q      <= rearm;
    end
  end

  btr_reward #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_reward (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .beam_level(beam_q),
    .reward_now(reward_now_q),
    .rearm     (rearm_q),
    .cfg       (cfg),
    .status    (rew_status)
  );

  btr_stim #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_stim (
    .clk    (clk),
    .rst    (rst),
    .go     (go),
    .trigger(rew_status.stim_trigger),
    .cfg    (cfg),
    .status (stim_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= go;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      solenoid_on    <= rew_status.solenoid_on;
      laser_level    <= stim_status.laser_level;
      nose_present   <= rew_status.nose_present;
      entry_event    <= rew_status.entry_event;
      exit_event     <= rew_status.exit_event;
      reward_started <= rew_status.reward_started;
      stim_started   <= stim_status.stim_started;
      stim_ended     <= stim_status.stim_ended;
    end
  end

endmodule
